>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/gmtm_pkg.sv
`timescale 1ns / 1ps

package gmtm_pkg;

   // request kinds carried in tuser
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STEP   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   // result kinds carried in tuser
   localparam logic RK_STEP  = 1'b0;
   localparam logic RK_TOTAL = 1'b1;

   // command from the sequencer to the pen unit
   typedef struct packed {
      logic              update;  // advance the pen
      logic              hit;     // glyph matched, track min x
      logic              clear;   // drop running values
      logic signed [7:0] off;
      logic        [7:0] wid;
   } pen_cmd_type;

endpackage

>>> rtl/glyph_match_text_measure.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Text measurement against a sorted glyph table held in one block RAM. A load
// beat writes one table entry and a finish beat emits the totals. A step beat
// binary-searches the table through the single read port, one probe per cycle,
// and then checks the final entry for a prefix match before its result goes
// into the output register. A step whose first window byte is zero loads its
// empty result into the output register as soon as it is accepted. The input
// is held off while a step is searching, and also while a result waits in the
// output register.
module glyph_match_text_measure
   import gmtm_pkg::*;
#(
   parameter int MAX_GLYPHS = 256,
   parameter int KEY_BYTES  = 4
) (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,   // glyph_count
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: glyph_slot[7:0], glyph_key[39:8], key_length[42:40],
   //        glyph_offset_x[50:43], glyph_wid[58:51], text_window[90:59]
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,     // operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: hit[0], glyph_index[8:1], consumed_bytes[11:9],
   //        text_width[27:12], text_x_offset[43:28]
   output logic [47:0] rsp_tdata,
   output logic [0:0]  rsp_tuser      // result_kind
);

   localparam int IDX_W = $clog2(MAX_GLYPHS);
   localparam int CNT_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
   localparam int KW    = 8 * KEY_BYTES;
   localparam int ENT_W = KW + 19;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CMP   = 3'b010,
      S_MATCH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [31:0]        win_ff, win_in;
   logic [7:0]         wid0_ff, wid0_in;
   logic [8:0]         glyph_count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_kind_ff, rsp_kind_in;

   // request fields
   op_type             req_op;
   logic [7:0]         req_slot;
   logic [31:0]        req_key;
   logic [2:0]         req_len;
   logic [7:0]         req_off;
   logic [7:0]         req_wid;
   logic [31:0]        req_win;

   logic               in_beat;
   logic               step_start;
   logic               out_free;
   logic               load_rsp;

   logic [CNT_W-1:0]   cnt_ext, cnt_eff, cnt_m1, slot_ext;
   logic               slot_ok;
   logic [2:0]         load_len;

   // table port
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENT_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENT_W-1:0]   ram_rd_data;

   // entry fields from the read port
   logic [KW-1:0]      ent_key;
   logic [2:0]         ent_len;
   logic [7:0]         ent_off;
   logic [7:0]         ent_wid;

   logic               at_or_below;
   logic [2:0]         prefix_len;
   logic               match_hit;
   logic [IDX_W-1:0]   lo_n, hi_n, hi0;

   pen_cmd_type        pen_cmd;
   logic signed [15:0] min_x, text_width;

   function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b} + (IDX_W+1)'(1);
      return s[IDX_W:1];
   endfunction

   // unpack the request beat
   assign req_op   = op_type'(req_tuser);
   assign req_slot = req_tdata[7:0];
   assign req_key  = req_tdata[39:8];
   assign req_len  = req_tdata[42:40];
   assign req_off  = req_tdata[50:43];
   assign req_wid  = req_tdata[58:51];
   assign req_win  = req_tdata[90:59];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign in_beat    = req_tvalid && req_tready;
   assign step_start = in_beat && (req_op == OP_STEP) && (req_win[31:24] != 8'd0);

   // effective count, clamped to 1..MAX_GLYPHS
   assign cnt_ext = CNT_W'(glyph_count_ff);
   always_comb begin
      if (cnt_ext == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (cnt_ext > CNT_W'(MAX_GLYPHS)) begin
         cnt_eff = CNT_W'(MAX_GLYPHS);
      end else begin
         cnt_eff = cnt_ext;
      end
   end
   assign cnt_m1 = cnt_eff - CNT_W'(1);
   assign hi0    = cnt_m1[IDX_W-1:0];

   // load: slot range and stored key length
   assign slot_ext = CNT_W'(req_slot);
   assign slot_ok  = slot_ext < CNT_W'(MAX_GLYPHS);

   always_comb begin
      logic       stop;
      logic [2:0] cap;
      stop = 1'b0;
      cap  = (req_len > 3'(KEY_BYTES)) ? 3'(KEY_BYTES) : req_len;
      load_len = 3'd0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (!stop && (3'(i) < cap) && (req_key[31-8*i -: 8] != 8'd0)) begin
            load_len = load_len + 3'd1;
         end else begin
            stop = 1'b1;
         end
      end
   end

   assign ram_wr_addr = slot_ext[IDX_W-1:0];
   assign ram_wr_data = {req_key[31 -: KW], load_len, req_off, req_wid};

   assign ent_wid = ram_rd_data[7:0];
   assign ent_off = ram_rd_data[15:8];
   assign ent_len = ram_rd_data[18:16];
   assign ent_key = ram_rd_data[ENT_W-1:19];

   gmtm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_GLYPHS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared compare unit, used by every probe and the final prefix check
   gmtm_key_cmp #(
      .KEY_BYTES (KEY_BYTES)
   ) u_cmp (
      .key         (ent_key),
      .key_len     (ent_len),
      .window      (win_ff),
      .at_or_below (at_or_below),
      .prefix_len  (prefix_len)
   );

   assign match_hit = (prefix_len != 3'd0);

   // narrowed search window after one probe
   assign lo_n = at_or_below ? mid_ff : lo_ff;
   assign hi_n = at_or_below ? hi_ff : (mid_ff - IDX_W'(1));

   gmtm_pen_unit u_pen (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pen_cmd),
      .min_x      (min_x),
      .text_width (text_width)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      win_in      = win_ff;
      wid0_in     = wid0_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mid_ff;
      load_rsp    = 1'b0;
      rsp_kind_in = RK_STEP;
      rsp_data_in = '0;
      pen_cmd     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_beat) begin
               unique case (req_op)
                  OP_LOAD: begin
                     if (slot_ok) begin
                        ram_wr_en = 1'b1;
                        if (req_slot == 8'd0) begin
                           wid0_in = req_wid;
                        end
                     end
                  end
                  OP_STEP: begin
                     win_in = req_win;
                     if (req_win[31:24] == 8'd0) begin
                        // end of text: empty step result
                        load_rsp = 1'b1;
                     end else begin
                        lo_in     = '0;
                        hi_in     = hi0;
                        ram_rd_en = 1'b1;
                        if (hi0 == '0) begin
                           ram_rd_addr = '0;
                           state_in    = S_MATCH;
                        end else begin
                           mid_in      = mid_of('0, hi0);
                           ram_rd_addr = mid_of('0, hi0);
                           state_in    = S_CMP;
                        end
                     end
                  end
                  OP_FINISH: begin
                     load_rsp      = 1'b1;
                     rsp_kind_in   = RK_TOTAL;
                     rsp_data_in   = {4'd0, min_x, text_width, 3'd0, 8'd0, 1'b0};
                     pen_cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CMP: begin
            lo_in     = lo_n;
            hi_in     = hi_n;
            ram_rd_en = 1'b1;
            if (lo_n == hi_n) begin
               ram_rd_addr = lo_n;
               state_in    = S_MATCH;
            end else begin
               mid_in      = mid_of(lo_n, hi_n);
               ram_rd_addr = mid_of(lo_n, hi_n);
            end
         end
         S_MATCH: begin
            if (out_free) begin
               load_rsp       = 1'b1;
               pen_cmd.update = 1'b1;
               pen_cmd.hit    = match_hit;
               if (match_hit) begin
                  pen_cmd.off = signed'(ent_off);
                  pen_cmd.wid = ent_wid;
                  rsp_data_in = {4'd0, 16'd0, 16'd0, prefix_len, 8'(lo_ff), 1'b1};
               end else begin
                  pen_cmd.off = 8'sd0;
                  pen_cmd.wid = wid0_ff;
                  rsp_data_in = {4'd0, 16'd0, 16'd0, 3'd1, 8'd0, 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         glyph_count_ff <= 9'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            glyph_count_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      win_ff  <= win_in;
      wid0_ff <= wid0_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // a probe only happens on a window of two or more entries
   `ASSERT_IMPLY(a_cmp_span, clock, reset, state_ff == S_CMP, lo_ff < hi_ff)
   // the final check always hands a beat to the output when it is free
   `ASSERT_NEXT(a_match_rsp, clock, reset, state_ff == S_MATCH && out_free, rsp_valid_ff)
   // a live step beat starts the search
   `ASSERT_NEXT(a_step_busy, clock, reset, step_start, state_ff != S_IDLE)

endmodule

>>> rtl/gmtm_ram.sv
`timescale 1ns / 1ps

module gmtm_ram #(
   parameter int WIDTH = 51,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gmtm_key_cmp.sv
`timescale 1ns / 1ps

module gmtm_key_cmp #(
   parameter int KEY_BYTES = 4
) (
   input  logic [8*KEY_BYTES-1:0] key,
   input  logic [2:0]             key_len,
   input  logic [31:0]            window,
   output logic                   at_or_below,
   output logic [2:0]             prefix_len
);

   localparam int KW = 8 * KEY_BYTES;

   // byte-wise ordering and prefix check, first byte in the top bits
   always_comb begin
      logic       done;
      logic       below;
      logic       equal;
      logic [7:0] kb;
      logic [7:0] tb;
      done  = 1'b0;
      below = 1'b1;
      equal = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         kb = key[KW-1-8*i -: 8];
         tb = window[31-8*i -: 8];
         if (3'(i) < key_len) begin
            if (kb != tb) begin
               equal = 1'b0;
            end
            if (!done) begin
               if (tb == 8'd0) begin
                  below = 1'b0;
                  done  = 1'b1;
               end else if (kb > tb) begin
                  below = 1'b0;
                  done  = 1'b1;
               end else if (kb < tb) begin
                  below = 1'b1;
                  done  = 1'b1;
               end
            end
         end
      end
      at_or_below = below;
      prefix_len  = equal ? key_len : 3'd0;
   end

endmodule

>>> rtl/gmtm_pen_unit.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gmtm_pen_unit
   import gmtm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pen_cmd_type        cmd,
   output logic signed [15:0] min_x,
   output logic signed [15:0] text_width
);

   localparam logic signed [17:0] SAT_HI = 18'sd32767;
   localparam logic signed [17:0] SAT_LO = -18'sd32768;

   logic signed [15:0] pen_x_ff, pen_x_in;
   logic signed [15:0] min_x_ff, min_x_in;
   logic               seen_ff, seen_in;

   logic signed [17:0] pen_ext, min_ext, off_ext, wid_ext;
   logic signed [17:0] sum_pen, sum_cand, diff;
   logic signed [15:0] cand;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > SAT_HI) begin
         return 16'sh7fff;
      end else if (v < SAT_LO) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // widened operands
   assign pen_ext  = 18'(pen_x_ff);
   assign min_ext  = 18'(min_x_ff);
   assign off_ext  = 18'(cmd.off);
   assign wid_ext  = signed'(18'(cmd.wid));
   assign sum_pen  = pen_ext + wid_ext + off_ext;
   assign sum_cand = pen_ext + off_ext;
   assign diff     = pen_ext - min_ext;
   assign cand     = sat16(sum_cand);

   // next running values
   always_comb begin
      pen_x_in = pen_x_ff;
      min_x_in = min_x_ff;
      seen_in  = seen_ff;
      if (cmd.clear) begin
         pen_x_in = '0;
         min_x_in = '0;
         seen_in  = 1'b0;
      end else if (cmd.update) begin
         pen_x_in = sat16(sum_pen);
         if (cmd.hit) begin
            seen_in = 1'b1;
            if (!seen_ff) begin
               min_x_in = 16'(cmd.off);
            end else if (cand < min_x_ff) begin
               min_x_in = cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         min_x_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         pen_x_ff <= pen_x_in;
         min_x_ff <= min_x_in;
         seen_ff  <= seen_in;
      end
   end

   assign min_x      = min_x_ff;
   assign text_width = sat16(diff);

   // min x holds zero until the first glyph lands
   `ASSERT_IMPLY(a_min_idle, clock, reset, !seen_ff, min_x_ff == 16'sd0)
   // the pen never falls left of the leftmost extent
   `ASSERT_IMPLY(a_min_le_pen, clock, reset, 1'b1, min_x_ff <= pen_x_ff)
   // a clear leaves no glyph seen
   `ASSERT_NEXT(a_clear, clock, reset, cmd.clear, !seen_ff && pen_x_ff == 16'sd0)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import gmtm_pkg::*;

   // reserved operation code, the block drops it
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int TABLE_DEPTH   = 256;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;
   localparam int STUCK_LIMIT   = 5000;
   localparam int RANDOM_COUNT  = -1;

   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        slot;
      logic [31:0]       key;
      logic [2:0]        klen;
      logic signed [7:0] off;
      logic [7:0]        wid;
      logic [31:0]       window;
   } measure_req_type;

   typedef struct packed {
      logic        kind;
      logic        hit;
      logic [7:0]  index;
      logic [2:0]  consumed;
      logic [15:0] width;
      logic [15:0] xoff;
   } measure_result_type;

   // how a directed row is checked
   typedef enum {CHK_MODEL, CHK_NONE, CHK_STEP_EMPTY, CHK_TOTAL_ZERO} check_kind_type;

   typedef struct {
      measure_req_type req;
      check_kind_type  chk;
   } stim_row_type;

   // shape of the generated glyph sets
   typedef enum {STYLE_MIXED, STYLE_LEFTWARD, STYLE_WIDE} layout_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // shadow of the block state
   logic [31:0] glyph_key_sh [TABLE_DEPTH];
   int          glyph_len_sh [TABLE_DEPTH];
   int          glyph_off_sh [TABLE_DEPTH];
   int          glyph_wid_sh [TABLE_DEPTH];
   int          pen_x_sh;
   int          min_x_sh;
   bit          seen_glyph_sh;
   logic [8:0]  glyph_count_sh;

   measure_result_type pending_results [$];
   measure_result_type oldest_result;
   int mismatches;

   // sorted key set currently loaded, used to build matching text
   logic [31:0]      layout_key [TABLE_DEPTH];
   int               layout_len [TABLE_DEPTH];
   int               layout_size = 0;
   layout_style_type layout_style = STYLE_MIXED;

   // traffic shaping shared with the receiver
   bit idle_on = 1'b1;
   int stall_asks = 0;
   int stall_seen = 0;
   int hold_left = 0;

   // per phase: glyph count, glyph style, finish rate per mille, items, idling
   int               phase_count  [13] = '{256, 511, 300, 257, 200, 128, 16, 16, 1, 2, 3, 0,
                                           RANDOM_COUNT};
   layout_style_type phase_style  [13] = '{STYLE_MIXED, STYLE_MIXED, STYLE_MIXED,
                                           STYLE_MIXED, STYLE_MIXED, STYLE_MIXED,
                                           STYLE_LEFTWARD, STYLE_WIDE, STYLE_MIXED,
                                           STYLE_MIXED, STYLE_MIXED, STYLE_MIXED,
                                           STYLE_MIXED};
   int               phase_finish [13] = '{40, 40, 40, 40, 40, 40, 0, 0, 60, 60, 60, 60, 50};
   int               phase_items  [13] = '{140, 80, 50, 40, 50, 50, 400, 260, 50, 50, 50, 40,
                                           60};
   bit               phase_idle   [13] = '{1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};

   glyph_match_text_measure u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] byte_of(logic [31:0] w, int i);
      return w[31 - 8 * i -: 8];
   endfunction

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // entry sorts at or below the text window, unsigned bytes
   function automatic bit sorts_at_or_below(int idx, logic [31:0] win);
      int i;
      logic [7:0] k;
      logic [7:0] t;
      for (i = 0; i < glyph_len_sh[idx]; i++) begin
         k = byte_of(glyph_key_sh[idx], i);
         t = byte_of(win, i);
         if (t == 8'd0) return 1'b0;
         if (k > t) return 1'b0;
         if (k < t) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic int prefix_bytes(int idx, logic [31:0] win);
      int i;
      for (i = 0; i < glyph_len_sh[idx]; i++) begin
         if (byte_of(glyph_key_sh[idx], i) != byte_of(win, i)) return 0;
      end
      return glyph_len_sh[idx];
   endfunction

   // next state of the measurement and the result beat a request causes
   function automatic void predict_measure(input measure_req_type r, output bit has_res,
                                           output measure_result_type res);
      int n;
      int cap;
      int count;
      int lo;
      int hi;
      int mid;
      int used;
      int cand;
      int w;
      has_res = 1'b0;
      res = '0;
      case (r.op)
         OP_LOAD: begin
            cap = (r.klen > 3'd4) ? 4 : int'(r.klen);
            n = 0;
            while (n < cap && byte_of(r.key, n) != 8'd0) n++;
            glyph_key_sh[r.slot] = r.key;
            glyph_len_sh[r.slot] = n;
            glyph_off_sh[r.slot] = int'($signed(r.off));
            glyph_wid_sh[r.slot] = int'(r.wid);
         end
         OP_STEP: begin
            has_res = 1'b1;
            res.kind = RK_STEP;
            if (byte_of(r.window, 0) == 8'd0) return;
            count = int'(glyph_count_sh);
            if (count == 0) count = 1;
            if (count > TABLE_DEPTH) count = TABLE_DEPTH;
            lo = 0;
            hi = count - 1;
            while (lo != hi) begin
               mid = (lo + hi + 1) / 2;
               if (sorts_at_or_below(mid, r.window)) lo = mid;
               else hi = mid - 1;
            end
            used = prefix_bytes(lo, r.window);
            // miss: advance by the fallback glyph width, one byte
            if (used == 0) begin
               pen_x_sh = clamp16(pen_x_sh + glyph_wid_sh[0]);
               res.consumed = 3'd1;
               return;
            end
            if (!seen_glyph_sh) begin
               min_x_sh = glyph_off_sh[lo];
            end else begin
               cand = clamp16(pen_x_sh + glyph_off_sh[lo]);
               if (cand < min_x_sh) min_x_sh = cand;
            end
            pen_x_sh = clamp16(pen_x_sh + glyph_wid_sh[lo] + glyph_off_sh[lo]);
            seen_glyph_sh = 1'b1;
            res.hit = 1'b1;
            res.index = lo[7:0];
            res.consumed = used[2:0];
         end
         OP_FINISH: begin
            has_res = 1'b1;
            res.kind = RK_TOTAL;
            w = clamp16(pen_x_sh - min_x_sh);
            res.width = w[15:0];
            res.xoff = min_x_sh[15:0];
            pen_x_sh = 0;
            min_x_sh = 0;
            seen_glyph_sh = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic stim_row_type mk_row(logic [1:0] op, logic [7:0] slot, logic [31:0] key,
                                           logic [2:0] klen, logic [7:0] off, logic [7:0] wid,
                                           logic [31:0] win, check_kind_type chk);
      stim_row_type row;
      row.req = '{op: op, slot: slot, key: key, klen: klen, off: off, wid: wid,
                  window: win};
      row.chk = chk;
      return row;
   endfunction

   // text byte, mostly from a narrow alphabet so keys share prefixes
   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(8'h41, 8'h48));
   endfunction

   function automatic void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, e, a);
         mismatches++;
      end
   endfunction

   // drive one request beat, wait for it to be taken, record what it causes
   task automatic send_beat(input measure_req_type r, input check_kind_type chk);
      bit has_res;
      measure_result_type res;
      measure_result_type lit;
      while (idle_on && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, r.window, r.wid, r.off, r.klen, r.key, r.slot};
      req_tuser <= r.op;
      do @(posedge clock); while (!req_tready);
      predict_measure(r, has_res, res);
      lit = '0;
      case (chk)
         CHK_MODEL: if (has_res) pending_results.push_back(res);
         CHK_STEP_EMPTY: begin
            lit.kind = RK_STEP;
            pending_results.push_back(lit);
         end
         CHK_TOTAL_ZERO: begin
            lit.kind = RK_TOTAL;
            pending_results.push_back(lit);
         end
         default: begin
         end
      endcase
   endtask

   // block idle: all results in and the last load retired
   task automatic settle_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_glyph_count(input logic [8:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      glyph_count_sh = v;
   endtask

   // generate a sorted key set of the given size and load it from slot 0
   task automatic build_layout(input int size, input layout_style_type style);
      int key_len_of [logic [31:0]];
      logic [31:0] k;
      int len;
      int b;
      int idx;
      measure_req_type r;
      while (key_len_of.num() < size) begin
         len = $urandom_range(1, 4);
         k = '0;
         for (b = 0; b < len; b++) k[31 - 8 * b -: 8] = text_byte();
         key_len_of[k] = len;
      end
      idx = 0;
      if (key_len_of.first(k)) begin
         do begin
            layout_key[idx] = k;
            layout_len[idx] = key_len_of[k];
            idx++;
         end while (key_len_of.next(k));
      end
      for (idx = 0; idx < size; idx++) begin
         r.op = OP_LOAD;
         r.slot = idx[7:0];
         r.key = layout_key[idx];
         r.klen = 3'(layout_len[idx]);
         // a length past the zero padding ends at the first zero byte
         if (layout_len[idx] < 4 && $urandom_range(0, 7) == 0)
            r.klen = 3'($urandom_range(layout_len[idx], 7));
         r.window = $urandom;
         case (style)
            STYLE_LEFTWARD: begin
               r.off = 8'(-$urandom_range(110, 128));
               r.wid = 8'($urandom_range(0, 5));
            end
            STYLE_WIDE: begin
               r.off = 8'($urandom_range(64, 127));
               r.wid = 8'($urandom_range(200, 255));
            end
            default: begin
               r.off = 8'($urandom);
               r.wid = 8'($urandom);
            end
         endcase
         send_beat(r, CHK_MODEL);
      end
      layout_size = size;
      layout_style = style;
   endtask

   // one random request, mostly text that runs into the loaded keys
   task automatic random_item(input int eff, input int finish_pm, output measure_req_type r);
      int p;
      int j;
      int b;
      bit ended;
      r.op = OP_STEP;
      r.slot = 8'($urandom);
      r.key = $urandom;
      r.klen = 3'($urandom);
      r.off = 8'($urandom);
      r.wid = 8'($urandom);
      r.window = $urandom;
      p = $urandom_range(0, 999);
      if (p < finish_pm) begin
         r.op = OP_FINISH;
      end else if (p < finish_pm + 20) begin
         r.op = OP_LOAD;
      end else if (p < finish_pm + 30) begin
         r.op = OP_RESERVED;
      end else if (p < finish_pm + 60) begin
         // end of text, with or without junk below the zero byte
         r.window[31:24] = 8'd0;
         if ($urandom_range(0, 1) == 0) r.window[23:0] = '0;
      end else if (p >= finish_pm + 140) begin
         j = $urandom_range(0, eff - 1);
         r.window = layout_key[j];
         ended = 1'b0;
         for (b = layout_len[j]; b < 4; b++) begin
            if (!ended && $urandom_range(0, 4) == 0) ended = 1'b1;
            if (!ended) r.window[31 - 8 * b -: 8] = text_byte();
         end
      end
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_asks != stall_seen) begin
         stall_seen <= stall_asks;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(0, 99) < 38);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, expected none actual %0h %0h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            compare_field("result_kind", oldest_result.kind, rsp_tuser[0]);
            compare_field("hit", oldest_result.hit, rsp_tdata[0]);
            compare_field("glyph_index", oldest_result.index, rsp_tdata[8:1]);
            compare_field("consumed_bytes", oldest_result.consumed, rsp_tdata[11:9]);
            compare_field("text_width", oldest_result.width, rsp_tdata[27:12]);
            compare_field("text_x_offset", oldest_result.xoff, rsp_tdata[43:28]);
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
      end
      $display("glyph_match_text_measure regression: fail");
      $finish;
   end

   // stimulus
   initial begin
      stim_row_type directed_rows [$];
      measure_req_type r;
      int ph;
      int n;
      int count;
      int eff;
      mismatches = 0;
      pen_x_sh = 0;
      min_x_sh = 0;
      seen_glyph_sh = 1'b0;
      glyph_count_sh = 9'd1;

      // count stays at its reset value of one through the directed rows
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h00000000,
                                     CHK_STEP_EMPTY));
      directed_rows.push_back(mk_row(OP_FINISH, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'd0,
                                     CHK_TOTAL_ZERO));
      directed_rows.push_back(mk_row(OP_RESERVED, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'd0,
                                     CHK_NONE));
      directed_rows.push_back(mk_row(OP_LOAD, 8'd0, 32'h41000000, 3'd1, 8'hFD, 8'd10, 32'd0,
                                     CHK_NONE));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h41420000,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h5A000000,
                                     CHK_MODEL));
      // end of text with junk in the lower bytes
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h00FFFFFF,
                                     CHK_STEP_EMPTY));
      directed_rows.push_back(mk_row(OP_FINISH, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'd0,
                                     CHK_MODEL));
      // empty key never matches
      directed_rows.push_back(mk_row(OP_LOAD, 8'd0, 32'h41000000, 3'd0, 8'd5, 8'd7, 32'd0,
                                     CHK_NONE));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h41000000,
                                     CHK_MODEL));
      // length above four is capped, extreme offset and width
      directed_rows.push_back(mk_row(OP_LOAD, 8'd0, 32'hFFFFFFFF, 3'd7, 8'h80, 8'd255,
                                     32'd0, CHK_NONE));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'hFFFFFFFF,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'hFFFFFFFE,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_FINISH, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'd0,
                                     CHK_MODEL));
      // key cut short by an inner zero byte
      directed_rows.push_back(mk_row(OP_LOAD, 8'd0, 32'h7F00FF00, 3'd4, 8'h7F, 8'd0, 32'd0,
                                     CHK_NONE));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h7F01FFFF,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_LOAD, 8'd255, 32'h80808080, 3'd4, 8'hFF, 8'd128,
                                     32'd0, CHK_NONE));
      directed_rows.push_back(mk_row(OP_LOAD, 8'd0, 32'h00000000, 3'd4, 8'd0, 8'd0, 32'd0,
                                     CHK_NONE));
      directed_rows.push_back(mk_row(OP_STEP, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'h01000000,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_FINISH, 8'd0, 32'd0, 3'd0, 8'd0, 8'd0, 32'd0,
                                     CHK_MODEL));
      directed_rows.push_back(mk_row(OP_RESERVED, 8'hFF, 32'hFFFFFFFF, 3'd7, 8'hFF, 8'hFF,
                                     32'hFFFFFFFF, CHK_NONE));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_beat(directed_rows[i].req, directed_rows[i].chk);
      req_tvalid <= 1'b0;

      // random phases, each under its own glyph count
      for (ph = 0; ph < 13; ph++) begin
         settle_idle();
         count = (phase_count[ph] == RANDOM_COUNT) ? $urandom_range(1, 64) : phase_count[ph];
         write_glyph_count(9'(count));
         eff = (count == 0) ? 1 : (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         idle_on <= phase_idle[ph];
         if (phase_style[ph] != layout_style || eff > layout_size)
            build_layout(eff, phase_style[ph]);
         for (n = 0; n < phase_items[ph]; n++) begin
            random_item(eff, phase_finish[ph], r);
            send_beat(r, CHK_MODEL);
            if (ph == 0 && n == 40) stall_asks <= stall_asks + 1;
         end
         req_tvalid <= 1'b0;
      end

      settle_idle();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("glyph_match_text_measure regression: pass");
      end else begin
         $display("glyph_match_text_measure regression: fail");
      end
      $finish;
   end

endmodule
